### sv/cfl_pkg.sv
package cfl_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned WINDOW_W = 16;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned BLOCK_W  = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_MS     = 2'd2;

  localparam logic [WINDOW_W-1:0] WINDOW_MS_RST    = 16'd1000;
  localparam logic [COUNT_W-1:0]  MAX_ATTEMPTS_RST = 16'd10;
  localparam logic [BLOCK_W-1:0]  BLOCK_MS_RST     = 24'd10000;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TIME_W-1:0]  TIME_MAX  = '1;

  typedef struct packed {
    logic [WINDOW_W-1:0] window_ms;
    logic [COUNT_W-1:0]  max_attempts;
    logic [BLOCK_W-1:0]  block_ms;
  } cfg_t;

  // query token walking the cell chain
  typedef struct packed {
    logic              valid;
    logic              done;      // some cell has answered, or the zero address was answered at injection
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] now;
    logic              accepted;
    logic              new_entry;
  } token_t;

  typedef struct packed {
    logic accepted;
    logic new_entry;
    logic table_full;
  } result_t;

endpackage

### sv/cfl_cell.sv
// One table entry. Answers the passing token on address match, or claims
// itself for an unknown source if it is the first free cell.
module cfl_cell (
  input  logic                clk,
  input  logic                rst,
  input  cfl_pkg::cfg_t       cfg,
  input  cfl_pkg::token_t     tok_in,
  output cfl_pkg::token_t     tok_out
);

  logic                              entry_valid;
  logic [cfl_pkg::ADDR_W-1:0]        entry_addr;
  logic [cfl_pkg::TIME_W-1:0]        window_start;
  logic [cfl_pkg::TIME_W-1:0]        blocked_until;
  logic [cfl_pkg::COUNT_W-1:0]       attempt_count;

  logic                              entry_valid_next;
  logic [cfl_pkg::ADDR_W-1:0]        entry_addr_next;
  logic [cfl_pkg::TIME_W-1:0]        window_start_next;
  logic [cfl_pkg::TIME_W-1:0]        blocked_until_next;
  logic [cfl_pkg::COUNT_W-1:0]       attempt_count_next;
  cfl_pkg::token_t                   tok_next;

  logic                              live;
  logic                              hit;
  logic [cfl_pkg::COUNT_W-1:0]       count_inc;
  logic [cfl_pkg::TIME_W-1:0]        elapsed;
  logic                              is_blocked;
  logic                              win_passed;
  logic [cfl_pkg::TIME_W:0]          block_sum;
  logic [cfl_pkg::TIME_W-1:0]        block_end;

  always_comb begin
    live       = tok_in.valid && !tok_in.done;
    hit        = live && entry_valid && (entry_addr == tok_in.addr);
    count_inc  = (attempt_count == cfl_pkg::COUNT_MAX) ? attempt_count
                                                       : attempt_count + 1'b1;
    elapsed    = tok_in.now - window_start;
    is_blocked = blocked_until > tok_in.now;
    win_passed = elapsed > {{(cfl_pkg::TIME_W-cfl_pkg::WINDOW_W){1'b0}}, cfg.window_ms};
    block_sum  = {1'b0, tok_in.now} +
                 {{(cfl_pkg::TIME_W+1-cfl_pkg::BLOCK_W){1'b0}}, cfg.block_ms};
    block_end  = block_sum[cfl_pkg::TIME_W] ? cfl_pkg::TIME_MAX
                                            : block_sum[cfl_pkg::TIME_W-1:0];

    entry_valid_next   = entry_valid;
    entry_addr_next    = entry_addr;
    window_start_next  = window_start;
    blocked_until_next = blocked_until;
    attempt_count_next = attempt_count;
    tok_next           = tok_in;

    if (hit) begin
      tok_next.done      = 1'b1;
      tok_next.new_entry = 1'b0;
      if (is_blocked) begin
        attempt_count_next = count_inc;
        tok_next.accepted  = 1'b0;
      end else if (win_passed) begin
        window_start_next  = tok_in.now;
        attempt_count_next = '0;
        if (count_inc > cfg.max_attempts) begin
          blocked_until_next = block_end;
          tok_next.accepted  = 1'b0;
        end else begin
          blocked_until_next = '0;
          tok_next.accepted  = 1'b1;
        end
      end else begin
        attempt_count_next = count_inc;
        tok_next.accepted  = 1'b1;
      end
    end else if (live && !entry_valid) begin
      // first free cell: valid cells always form a prefix of the chain
      entry_valid_next   = 1'b1;
      entry_addr_next    = tok_in.addr;
      window_start_next  = tok_in.now;
      blocked_until_next = '0;
      attempt_count_next = {{(cfl_pkg::COUNT_W-1){1'b0}}, 1'b1};
      tok_next.done      = 1'b1;
      tok_next.accepted  = 1'b1;
      tok_next.new_entry = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid   <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      entry_valid   <= entry_valid_next;
      tok_out.valid <= tok_next.valid;
    end
    entry_addr         <= entry_addr_next;
    window_start       <= window_start_next;
    blocked_until      <= blocked_until_next;
    attempt_count      <= attempt_count_next;
    tok_out.done       <= tok_next.done;
    tok_out.addr       <= tok_next.addr;
    tok_out.now        <= tok_next.now;
    tok_out.accepted   <= tok_next.accepted;
    tok_out.new_entry  <= tok_next.new_entry;
  end

endmodule

### sv/connection_flood_limiter.sv
// Per-source connection flood limiter.
// Input channel (in_valid/in_stall): one beat is one connection attempt,
// source_addr plus the current time now_ms in milliseconds.
// Output channel (out_valid/out_stall): one beat per attempt, in order, with
// accepted, new_entry and table_full.
// Config port: cfg_wr_en writes cfg_data into register cfg_index
// (0 window_ms, 1 max_attempts, 2 block_ms); other indexes are ignored.
// Write only while idle.
// The attempt walks a row of TABLE_ENTRIES cells, one per cycle, and then
// the pending register and the output register. One attempt is in the row
// at a time: a new attempt is taken only once the last result has left the
// pending register.
// A finished result that is stalled at the output waits in the output
// register while the next attempt is already taken and walks the row.
// Reset clears all entries and restores the register defaults; no
// clearing pass is needed, the block takes a beat right after reset.
module connection_flood_limiter #(
  parameter int unsigned TABLE_ENTRIES = cfl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [cfl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cfl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cfl_pkg::ADDR_W-1:0]    source_addr,
  input  logic [cfl_pkg::TIME_W-1:0]    now_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          accepted,
  output logic                          new_entry,
  output logic                          table_full
);

  cfl_pkg::cfg_t    cfg;
  cfl_pkg::token_t  chain [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES:0] chain_vld;

  // busy from accept until the result leaves the pending register
  logic             busy;
  logic             pend_valid;
  cfl_pkg::result_t pend;
  cfl_pkg::result_t res;
  logic             in_take;
  logic             pend_move;
  cfl_pkg::token_t  tail;

  assign in_stall  = busy;
  assign in_take   = in_valid && !busy;
  assign pend_move = pend_valid && (!out_valid || !out_stall);
  assign tail      = chain[TABLE_ENTRIES];

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_ms    <= cfl_pkg::WINDOW_MS_RST;
      cfg.max_attempts <= cfl_pkg::MAX_ATTEMPTS_RST;
      cfg.block_ms     <= cfl_pkg::BLOCK_MS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cfl_pkg::REG_WINDOW_MS:    cfg.window_ms    <= cfg_data[cfl_pkg::WINDOW_W-1:0];
        cfl_pkg::REG_MAX_ATTEMPTS: cfg.max_attempts <= cfg_data[cfl_pkg::COUNT_W-1:0];
        cfl_pkg::REG_BLOCK_MS:     cfg.block_ms     <= cfg_data[cfl_pkg::BLOCK_W-1:0];
        default: ;
      endcase
    end
  end

  // token injection; a zero address is answered (reject) before the row
  always_comb begin
    chain[0].valid     = in_take;
    chain[0].done      = (source_addr == '0);
    chain[0].addr      = source_addr;
    chain[0].now       = now_ms;
    chain[0].accepted  = 1'b0;
    chain[0].new_entry = 1'b0;
  end

  genvar g;
  generate
    for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      cfl_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .cfg     (cfg),
        .tok_in  (chain[g]),
        .tok_out (chain[g+1])
      );
    end
    for (g = 0; g <= TABLE_ENTRIES; g++) begin : g_vld
      assign chain_vld[g] = chain[g].valid;
    end
  endgenerate

  // tail -> pending -> output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_take) begin
        busy <= 1'b1;
      end else if (pend_move) begin
        busy <= 1'b0;
      end
      if (tail.valid) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (pend_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (tail.valid) begin
      // a token nobody answered: unknown source and every cell in use
      pend.accepted   <= tail.done ? tail.accepted : 1'b1;
      pend.new_entry  <= tail.done && tail.new_entry;
      pend.table_full <= !tail.done;
    end
    if (pend_move) begin
      res <= pend;
    end
  end

  assign accepted   = res.accepted;
  assign new_entry  = res.new_entry;
  assign table_full = res.table_full;

  // at most one attempt in the row
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(chain_vld))
    else $error("more than one token in the cell row");

  // a token inside the row (past injection) implies the block is busy
  a_busy_tok: assert property (@(posedge clk) disable iff (rst)
    (chain_vld[TABLE_ENTRIES:1] != '0) |-> busy)
    else $error("token in row while idle");

  // pending result never overwritten by a new tail token
  a_pend_free: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> !pend_valid)
    else $error("tail token while pending result not moved");

  // a created entry is always an accept, and never flagged as full
  a_new_acc: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_entry |-> accepted && !table_full)
    else $error("new entry with reject or full flag");

  // full table answers accept
  a_full_acc: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> accepted)
    else $error("table full without accept");

endmodule
